// ===== design/repeat_event_throttle_defines.svh =====
// Assertion macros for the event throttle
`ifndef REPEAT_EVENT_THROTTLE_DEFINES_SVH
`define REPEAT_EVENT_THROTTLE_DEFINES_SVH
`ifndef SYNTHESIS
`define RET_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RET_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RET_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RET_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== design/ret_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ret_pkg;
    localparam int EventSlots = 16;
    localparam int KeyBits    = 32;
    localparam int SlotIdxW   = $clog2(EventSlots);
    localparam int CountW     = $clog2(EventSlots + 1);
    localparam logic [2:0] FatalLevel = 3'd7;
    localparam logic [15:0] RepeatMax = 16'hFFFF;
    localparam logic [31:0] SuppMax   = 32'hFFFF_FFFF;

    localparam logic OpConsider = 1'b0;
    localparam logic OpDrain    = 1'b1;

    localparam logic [1:0] RegEnable   = 2'd0;
    localparam logic [1:0] RegInterval = 2'd1;
    localparam logic [1:0] RegNth      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DRAIN,
        ST_OUT,
        ST_DRAIN_OUT
    } state_t;

    typedef struct packed {
        logic load;       // capture input beat
        logic consider;   // do lookup/update
        logic drain_step; // examine slot at drain index
        logic drain_adv;
    } cmd_t;

    typedef struct packed {
        logic is_drain;
        logic drain_hit;  // current drain slot owes counts
        logic drain_done; // index past entries
    } status_t;
endpackage
`default_nettype wire

// ===== design/ret_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ret_datapath
    import ret_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    output status_t                  status,
    input  wire logic                cfg_enable,
    input  wire logic [31:0]         cfg_interval,
    input  wire logic [15:0]         cfg_nth,
    input  wire logic                in_op,
    input  wire logic [2:0]          in_sev,
    input  wire logic [KeyBits-1:0]  in_key,
    input  wire logic signed [63:0]  in_now,
    output logic                     r_emit,
    output logic [31:0]              r_held,
    output logic                     r_sv,
    output logic [2:0]               r_ssev,
    output logic [KeyBits-1:0]       r_skey,
    output logic [31:0]              r_scount
);
    logic [2:0]         sev_q  [EventSlots];
    logic [KeyBits-1:0] key_q  [EventSlots];
    logic signed [63:0] emt_q  [EventSlots];
    logic signed [63:0] seen_q [EventSlots];
    logic [15:0]        rep_q  [EventSlots];
    logic [31:0]        sup_q  [EventSlots];
    logic [CountW-1:0]  count_reg, count_next;
    logic [CountW-1:0]  didx_reg;
    logic               op_reg;
    logic [2:0]         isev_reg;
    logic [KeyBits-1:0] ikey_reg;
    logic signed [63:0] inow_reg;

    // parallel match
    logic               hit;
    logic [SlotIdxW-1:0] hidx, oidx;
    always_comb begin
        hit = 1'b0; hidx = '0;
        for (int i = EventSlots - 1; i >= 0; i--) begin
            if (i < count_reg && sev_q[i] == isev_reg && key_q[i] == ikey_reg) begin
                hit = 1'b1; hidx = SlotIdxW'(i);
            end
        end
    end

    // oldest search as a compare tree; ties keep the left (earlier) slot
    logic signed [63:0]  tree_seen [1:2*EventSlots-1];
    logic [SlotIdxW-1:0] tree_idx  [1:2*EventSlots-1];
    always_comb begin
        for (int i = 0; i < EventSlots; i++) begin
            tree_seen[EventSlots + i] = seen_q[i];
            tree_idx[EventSlots + i]  = SlotIdxW'(i);
        end
        for (int n = EventSlots - 1; n >= 1; n--) begin
            if (tree_seen[2*n+1] < tree_seen[2*n]) begin
                tree_seen[n] = tree_seen[2*n+1];
                tree_idx[n]  = tree_idx[2*n+1];
            end else begin
                tree_seen[n] = tree_seen[2*n];
                tree_idx[n]  = tree_idx[2*n];
            end
        end
        oidx = tree_idx[1];
    end

    logic [15:0] rep_inc;
    logic        passed, nth_ok, emit_hit;
    logic signed [64:0] elapsed;
    always_comb begin
        rep_inc = (rep_q[hidx] < RepeatMax) ? rep_q[hidx] + 16'd1 : rep_q[hidx];
        elapsed = {inow_reg[63], inow_reg} - {emt_q[hidx][63], emt_q[hidx]};
        passed  = (cfg_interval == 32'd0) || (inow_reg < emt_q[hidx])
                  || (elapsed >= 65'($unsigned(cfg_interval)));
        nth_ok  = (cfg_nth > 16'd1) && (rep_inc >= cfg_nth);
        emit_hit = passed || nth_ok;
    end

    logic               pass_thru;
    logic               evict_sum;
    logic [SlotIdxW-1:0] didx;
    assign pass_thru = !cfg_enable || isev_reg == FatalLevel;
    assign evict_sum = !pass_thru && !hit && count_reg == CountW'(EventSlots)
                       && sup_q[oidx] != 32'd0;
    assign didx = didx_reg[SlotIdxW-1:0];
    assign status.is_drain   = op_reg == OpDrain;
    assign status.drain_done = didx_reg >= count_reg;
    assign status.drain_hit  = (didx_reg < count_reg) && (sup_q[didx] != 32'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            didx_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.load) didx_reg <= '0;
            else if (cmd.drain_adv) didx_reg <= didx_reg + CountW'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.consider && !pass_thru && !hit && count_reg < CountW'(EventSlots))
            count_next = count_reg + CountW'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_op; isev_reg <= in_sev; ikey_reg <= in_key; inow_reg <= in_now;
        end
        if (cmd.consider) begin
            r_emit   <= pass_thru || !hit || emit_hit;
            r_held   <= (!pass_thru && hit && emit_hit) ? sup_q[hidx] : 32'd0;
            r_sv     <= evict_sum;
            r_ssev   <= evict_sum ? sev_q[oidx] : 3'd0;
            r_skey   <= evict_sum ? key_q[oidx] : '0;
            r_scount <= evict_sum ? sup_q[oidx] : 32'd0;
            if (!pass_thru) begin
                if (hit) begin
                    seen_q[hidx] <= inow_reg;
                    if (emit_hit) begin
                        sup_q[hidx] <= '0; rep_q[hidx] <= '0; emt_q[hidx] <= inow_reg;
                    end else begin
                        rep_q[hidx] <= rep_inc;
                        if (sup_q[hidx] < SuppMax) sup_q[hidx] <= sup_q[hidx] + 32'd1;
                    end
                end else if (count_reg < CountW'(EventSlots)) begin
                    sev_q[count_reg[SlotIdxW-1:0]]  <= isev_reg;
                    key_q[count_reg[SlotIdxW-1:0]]  <= ikey_reg;
                    emt_q[count_reg[SlotIdxW-1:0]]  <= inow_reg;
                    seen_q[count_reg[SlotIdxW-1:0]] <= inow_reg;
                    rep_q[count_reg[SlotIdxW-1:0]]  <= '0;
                    sup_q[count_reg[SlotIdxW-1:0]]  <= '0;
                end else begin
                    // compact list, append at the tail
                    for (int i = 0; i < EventSlots - 1; i++) begin
                        if (i >= oidx) begin
                            sev_q[i] <= sev_q[i+1]; key_q[i] <= key_q[i+1];
                            emt_q[i] <= emt_q[i+1]; seen_q[i] <= seen_q[i+1];
                            rep_q[i] <= rep_q[i+1]; sup_q[i] <= sup_q[i+1];
                        end
                    end
                    sev_q[EventSlots-1] <= isev_reg; key_q[EventSlots-1] <= ikey_reg;
                    emt_q[EventSlots-1] <= inow_reg; seen_q[EventSlots-1] <= inow_reg;
                    rep_q[EventSlots-1] <= '0; sup_q[EventSlots-1] <= '0;
                end
            end
        end
        if (cmd.drain_step && didx_reg < count_reg) begin
            rep_q[didx] <= '0;
            if (sup_q[didx] != 32'd0) begin
                r_emit <= 1'b0; r_held <= '0; r_sv <= 1'b1;
                r_ssev <= sev_q[didx]; r_skey <= key_q[didx]; r_scount <= sup_q[didx];
                sup_q[didx] <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/ret_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "repeat_event_throttle_defines.svh"
module ret_ctrl
    import ret_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic         m_last,
    output cmd_t         cmd,
    input  wire status_t status
);
    state_t state_reg, state_next;
    logic   hasr_reg, hasr_next; // a drain result is pending search for last

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hasr_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            hasr_reg  <= hasr_next;
        end
    end

    // drain: step one slot a cycle while in ST_DRAIN; an owing slot is latched and held until the next
    // owing slot is found, then offered in ST_DRAIN_OUT, so last is known when it leaves.
    always_comb begin
        state_next = state_reg;
        hasr_next  = hasr_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_LOOKUP;
            ST_LOOKUP: begin
                state_next = status.is_drain ? ST_DRAIN : ST_OUT;
                hasr_next  = 1'b0;
            end
            ST_DRAIN: begin
                if (status.drain_done)
                    state_next = hasr_reg ? ST_OUT : ST_IDLE;
                else if (status.drain_hit && hasr_reg)
                    state_next = ST_DRAIN_OUT;
                else if (status.drain_hit)
                    hasr_next = 1'b1;
            end
            ST_DRAIN_OUT: if (m_tready) state_next = ST_DRAIN;
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_tready = 1'b0; m_tvalid = 1'b0; m_last = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_LOOKUP: cmd.consider = !status.is_drain;
            ST_DRAIN: begin
                if (!status.drain_done && !(status.drain_hit && hasr_reg)) begin
                    cmd.drain_step = 1'b1; cmd.drain_adv = 1'b1;
                end
            end
            ST_DRAIN_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.drain_step = 1'b1; cmd.drain_adv = 1'b1;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1; m_last = 1'b1;
            end
            default: ;
        endcase
    end

    `RET_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    `RET_ASSERT_NEXT(a_load_lookup, aclk, aresetn, cmd.load, state_reg == ST_LOOKUP)
    `RET_ASSERT_IMPL(a_last_only_out, aclk, aresetn, m_last, state_reg == ST_OUT)
endmodule
`default_nettype wire

// ===== design/repeat_event_throttle.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  beat contents
// s_        in   tdata: operation, severity, event_key, now_ms
// m_        out  tdata: emit, held_count, summary_*; tlast = last
// cfg_      in   wr_en, index, wr_data
// A consider goes through capture, lookup/update and result, plus output wait.
// A drain walks every entry of the list and outputs each owing result, plus output wait.
// Reset (aresetn low, sync) empties the list; slot contents are not cleared.
// Output stall holds the controller; no new beat is taken until the last result leaves.
module repeat_event_throttle
    import ret_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [0] operation, [3:1] severity, [35:4] event_key, [99:36] now_ms
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [0] emit, [32:1] held_count, [33] summary_valid, [36:34] summary_severity,
    // [68:37] summary_key, [100:69] summary_count
    output logic [103:0]      m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wr_data
);
    logic        en_reg;
    logic [31:0] iv_reg;
    logic [15:0] nth_reg;
    cmd_t        cmd;
    status_t     status;
    logic        r_emit, r_sv;
    logic [31:0] r_held, r_scount;
    logic [2:0]  r_ssev;
    logic [KeyBits-1:0] r_skey;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0; iv_reg <= '0; nth_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                RegEnable:   en_reg  <= cfg_wr_data[0];
                RegInterval: iv_reg  <= cfg_wr_data;
                RegNth:      nth_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    ret_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .m_last(m_tlast), .cmd, .status
    );

    ret_datapath u_dp (
        .aclk, .aresetn, .cmd, .status,
        .cfg_enable(en_reg), .cfg_interval(iv_reg), .cfg_nth(nth_reg),
        .in_op(s_tdata[0]), .in_sev(s_tdata[3:1]), .in_key(s_tdata[35:4]),
        .in_now(s_tdata[99:36]),
        .r_emit, .r_held, .r_sv, .r_ssev, .r_skey, .r_scount
    );

    assign m_tdata = {3'b000, r_scount, r_skey, r_ssev, r_sv, r_held, r_emit};
endmodule
`default_nettype wire

// ===== verif/repeat_event_throttle_checker.sv =====
`timescale 1ns / 1ps
module repeat_event_throttle_checker
    import ret_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [103:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [103:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wr_data,
    output int                pending,
    output int                fail_count,
    output int                result_count
);
    typedef struct packed {
        logic        emit;
        logic [31:0] held;
        logic        sum_valid;
        logic [2:0]  sum_sev;
        logic [31:0] sum_key;
        logic [31:0] sum_count;
        logic        last;
    } verdict_t;

    verdict_t    owed_verdicts[$];

    logic        thr_en;
    logic [31:0] min_gap;
    logic [15:0] nth;

    int          n_entries;
    logic [2:0]  ev_sev[EventSlots];
    logic [31:0] ev_key[EventSlots];
    longint      ev_emitted[EventSlots];
    longint      ev_seen[EventSlots];
    logic [15:0] ev_repeats[EventSlots];
    logic [31:0] ev_supp[EventSlots];

    assign pending = owed_verdicts.size();

    function automatic verdict_t blank();
        verdict_t v;
        v = '0;
        v.last = 1'b1;
        return v;
    endfunction

    function automatic void owe(verdict_t v);
        owed_verdicts = {owed_verdicts, v};
    endfunction

    function automatic bit gap_elapsed(longint now_t, longint then_t);
        logic [63:0] elapsed;
        if (min_gap == 0 || now_t < then_t) return 1'b1;
        elapsed = now_t - then_t;
        return elapsed >= {32'd0, min_gap};
    endfunction

    task automatic throttle_event(logic [2:0] sev, logic [31:0] key, longint now_t);
        verdict_t v;
        int hit;
        int oldest;
        v = blank();
        hit = -1;
        if (!thr_en || sev == FatalLevel) begin
            v.emit = 1'b1;
            owe(v);
            return;
        end
        for (int i = 0; i < n_entries; i++) begin
            if (hit < 0 && ev_sev[i] == sev && ev_key[i] == key) hit = i;
        end
        if (hit < 0) begin
            if (n_entries >= EventSlots) begin
                oldest = 0;
                for (int i = 1; i < EventSlots; i++)
                    if (ev_seen[i] < ev_seen[oldest]) oldest = i;
                if (ev_supp[oldest] != 0) begin
                    v.sum_valid = 1'b1;
                    v.sum_sev   = ev_sev[oldest];
                    v.sum_key   = ev_key[oldest];
                    v.sum_count = ev_supp[oldest];
                end
                // compact the list over the evicted slot
                for (int i = oldest; i < n_entries - 1; i++) begin
                    ev_sev[i]     = ev_sev[i+1];
                    ev_key[i]     = ev_key[i+1];
                    ev_emitted[i] = ev_emitted[i+1];
                    ev_seen[i]    = ev_seen[i+1];
                    ev_repeats[i] = ev_repeats[i+1];
                    ev_supp[i]    = ev_supp[i+1];
                end
                n_entries--;
            end
            ev_sev[n_entries]     = sev;
            ev_key[n_entries]     = key;
            ev_emitted[n_entries] = now_t;
            ev_seen[n_entries]    = now_t;
            ev_repeats[n_entries] = '0;
            ev_supp[n_entries]    = '0;
            n_entries++;
            v.emit = 1'b1;
            owe(v);
            return;
        end
        ev_seen[hit] = now_t;
        if (ev_repeats[hit] != RepeatMax) ev_repeats[hit]++;
        if (!gap_elapsed(now_t, ev_emitted[hit]) &&
            !(nth > 1 && ev_repeats[hit] >= nth)) begin
            if (ev_supp[hit] != SuppMax) ev_supp[hit]++;
            owe(v);
            return;
        end
        v.emit = 1'b1;
        v.held = ev_supp[hit];
        owe(v);
        ev_supp[hit]    = '0;
        ev_repeats[hit] = '0;
        ev_emitted[hit] = now_t;
    endtask

    task automatic drain_owed();
        verdict_t v;
        int k;
        k = 0;
        for (int i = 0; i < n_entries; i++) begin
            if (ev_supp[i] != 0 && k < EventSlots) begin
                v = '0;
                v.sum_valid = 1'b1;
                v.sum_sev   = ev_sev[i];
                v.sum_key   = ev_key[i];
                v.sum_count = ev_supp[i];
                owe(v);
                ev_supp[i] = '0;
                k++;
            end
            ev_repeats[i] = '0;
        end
        if (k > 0) owed_verdicts[owed_verdicts.size()-1].last = 1'b1;
    endtask

    task automatic compare_beat();
        verdict_t want;
        verdict_t got;
        got = {m_tdata[0], m_tdata[32:1], m_tdata[33], m_tdata[36:34],
               m_tdata[68:37], m_tdata[100:69], m_tlast};
        result_count++;
        if (owed_verdicts.size() == 0) begin
            $error("unexpected result beat %h", m_tdata);
            fail_count++;
            return;
        end
        want = owed_verdicts.pop_front();
        if (got.emit !== want.emit) begin
            $error("emit: expected %0d, got %0d", want.emit, got.emit); fail_count++;
        end
        if (got.held !== want.held) begin
            $error("held_count: expected %0d, got %0d", want.held, got.held); fail_count++;
        end
        if (got.sum_valid !== want.sum_valid) begin
            $error("summary_valid: expected %0d, got %0d", want.sum_valid, got.sum_valid);
            fail_count++;
        end
        if (got.sum_sev !== want.sum_sev) begin
            $error("summary_severity: expected %0d, got %0d", want.sum_sev, got.sum_sev);
            fail_count++;
        end
        if (got.sum_key !== want.sum_key) begin
            $error("summary_key: expected %h, got %h", want.sum_key, got.sum_key);
            fail_count++;
        end
        if (got.sum_count !== want.sum_count) begin
            $error("summary_count: expected %0d, got %0d", want.sum_count, got.sum_count);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_en       = 1'b0;
            min_gap      = '0;
            nth          = '0;
            n_entries    = 0;
            fail_count   = 0;
            result_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    RegEnable:   thr_en  = cfg_wr_data[0];
                    RegInterval: min_gap = cfg_wr_data;
                    RegNth:      nth     = cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tdata[0] == OpDrain) drain_owed();
                else throttle_event(s_tdata[3:1], s_tdata[35:4], s_tdata[99:36]);
            end
            if (m_tvalid && m_tready) compare_beat();
        end
    end

    final begin
        if (owed_verdicts.size() != 0)
            $error("%0d expected results never arrived", owed_verdicts.size());
    end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import ret_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_wr_data;
    int           pending;
    int           fail_count;
    int           result_count;

    logic [2:0]   pool_sev[22];
    logic [31:0]  pool_key[22];
    longint       clock_ms;
    int           beats_sent;
    int           drains_sent;
    int           ready_run = 0;
    logic         ready_level = 1'b1;

    repeat_event_throttle dut (.*);

    repeat_event_throttle_checker scoreboard (.*);

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("repeat_event_throttle regression: fail");
        $finish;
    end

    // result-side backpressure: long ready runs, short stalls, occasional long stalls
    always @(negedge aclk) begin
        if (ready_run > 0) begin
            ready_run--;
        end else begin
            case ($urandom_range(0, 9))
                0: begin ready_level = 1'b0; ready_run = $urandom_range(10, 30); end
                1, 2, 3: begin ready_level = 1'b0; ready_run = $urandom_range(0, 3); end
                default: begin ready_level = 1'b1; ready_run = $urandom_range(1, 40); end
            endcase
        end
        m_tready = ready_level;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_beat(logic op, logic [2:0] sev, logic [31:0] key, longint now_t,
                             int gap);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, now_t, key, sev, op};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (op == OpDrain) drains_sent++;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge aclk);
        // a drain that owes nothing leaves no result but still walks the list
        repeat (60) @(posedge aclk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic random_traffic(int count);
        int     p;
        int     r;
        logic [2:0]  sev;
        logic [31:0] key;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) clock_ms = {$urandom, $urandom};
            else if (r < 8) clock_ms -= $urandom_range(1, 1000);
            else clock_ms += $urandom_range(0, 300);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_beat(OpDrain, 3'($urandom), $urandom, {$urandom, $urandom}, pick_gap());
            end else begin
                p   = $urandom_range(0, 21);
                sev = pool_sev[p];
                key = pool_key[p];
                if (r < 14) begin
                    sev = 3'($urandom);
                    key = $urandom;
                end else if (r < 17) begin
                    sev = FatalLevel;
                end
                send_beat(OpConsider, sev, key, clock_ms, pick_gap());
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = RegEnable;
        cfg_wr_data = '0;
        beats_sent  = 0;
        drains_sent = 0;
        clock_ms    = 1000;
        for (int i = 0; i < 22; i++) begin
            pool_sev[i] = 3'($urandom_range(0, 6));
            pool_key[i] = $urandom;
        end
        pool_key[0] = 32'h0000_0000;
        pool_key[1] = 32'hFFFF_FFFF;
        pool_sev[1] = 3'd0;
        pool_sev[2] = 3'd6;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // throttling off after reset: everything passes, nothing is stored
        send_beat(OpConsider, 3'd2, 32'h1234_5678, 64'sd5, 0);
        send_beat(OpDrain, 3'd0, 32'd0, 64'sd0, 1);
        settle();

        write_reg(RegEnable, 32'd1);
        write_reg(RegInterval, 32'd100);
        write_reg(RegNth, 32'd3);
        send_beat(OpConsider, FatalLevel, 32'hAAAA_0001, 64'sd1000, 0);
        send_beat(OpConsider, 3'd3, 32'hAAAA_0001, 64'sd1000, 0);  // first sighting
        send_beat(OpConsider, 3'd3, 32'hAAAA_0001, 64'sd1010, 2);  // held back
        send_beat(OpConsider, 3'd3, 32'hAAAA_0001, 64'sd1020, 0);  // held back
        send_beat(OpConsider, 3'd3, 32'hAAAA_0001, 64'sd1030, 0);  // nth repeat emits
        send_beat(OpConsider, 3'd3, 32'hAAAA_0001, 64'sd900, 0);   // time ran backwards
        send_beat(OpDrain, 3'd0, 32'd0, 64'sd0, 0);                // nothing owed
        send_beat(OpConsider, 3'd3, 32'hAAAA_0001, 64'sd950, 0);
        send_beat(OpConsider, 3'd4, 32'hAAAA_0001, 64'sd951, 0);   // same key, other level
        send_beat(OpConsider, 3'd4, 32'hAAAA_0001, 64'sd960, 0);
        send_beat(OpDrain, 3'd0, 32'd0, 64'sd0, 3);
        send_beat(OpConsider, 3'd0, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 0);
        send_beat(OpConsider, 3'd0, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_beat(OpConsider, 3'd6, 32'h0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_beat(OpConsider, 3'd6, 32'h0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        send_beat(OpConsider, 3'd6, 32'h0000_0000, 64'h8000_0000_0000_0000, 0);
        send_beat(OpConsider, 3'd0, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 0);
        send_beat(OpDrain, 3'd0, 32'd0, 64'sd0, 0);
        settle();

        // several settings, extremes included; the list carries across phases
        random_traffic(60);
        settle();
        write_reg(RegInterval, 32'hFFFF_FFFF);
        write_reg(RegNth, 32'd65535);
        random_traffic(60);
        settle();
        write_reg(RegInterval, 32'd0);
        write_reg(RegNth, 32'd0);
        random_traffic(50);
        settle();
        write_reg(RegInterval, 32'd250);
        write_reg(RegNth, 32'd1);
        random_traffic(60);
        settle();
        write_reg(RegNth, 32'd2);
        write_reg(RegInterval, 32'd50);
        random_traffic(60);
        settle();
        write_reg(RegEnable, 32'd0);
        random_traffic(20);
        settle();
        write_reg(RegEnable, 32'hFFFF_FFFF);
        write_reg(RegNth, 32'hFFFF_0004);
        random_traffic(40);
        settle();

        $display("sent %0d beats (%0d drains) over seven register settings,", beats_sent,
                 drains_sent);
        $display("checked %0d result beats", result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("repeat_event_throttle regression: pass");
        end else begin
            $display("repeat_event_throttle regression: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/ret_pkg.sv
design/ret_datapath.sv
design/ret_ctrl.sv
design/repeat_event_throttle.sv
verif/repeat_event_throttle_checker.sv
verif/testbench.sv
